@@ hw/rtl/ewr_pkg.sv @@
// Shared types and constants for the email word recognizer.
package ewr_pkg;

    localparam int COUNT_WIDTH = 16;
    localparam int CMP_WIDTH   = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;

    localparam int CFG_INDEX_WIDTH = 2;
    localparam int CFG_DATA_WIDTH  = 16;

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_FIRST_INDEX   = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_LAST_INDEX    = 2'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_KEEP_NEWLINES = 2'd2;

    localparam logic [15:0] LAST_INDEX_RESET = 16'd100;

    typedef struct packed {
        logic done;
        logic email;
    } word_end_t;

endpackage

@@ hw/rtl/ewr_scan.sv @@
// Word splitter and byte-serial address pattern scanner.
module ewr_scan (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic [7:0]        text_byte,
    input  logic              end_of_text,
    input  logic              keep_newlines,
    output ewr_pkg::word_end_t word_end
);
    import ewr_pkg::*;

    localparam logic [2:0] PH_LOCAL_EMPTY = 3'd0;
    localparam logic [2:0] PH_LOCAL       = 3'd1;
    localparam logic [2:0] PH_AT          = 3'd2;
    localparam logic [2:0] PH_DOMAIN      = 3'd3;
    localparam logic [2:0] PH_TAIL        = 3'd4;
    localparam logic [2:0] PH_FAIL        = 3'd7;

    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_LF      = 8'h0A;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_AT      = 8'h40;
    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_UNDER   = 8'h5F;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_PLUS    = 8'h2B;

    logic       word_open_reg, word_open_next;
    logic [2:0] phase_reg, phase_next;
    logic [1:0] tail_reg, tail_next;
    logic       is_letter, is_digit, is_local;

    always_comb
    begin
        is_letter = (text_byte >= 8'h61 && text_byte <= 8'h7A) ||
                    (text_byte >= 8'h41 && text_byte <= 8'h5A);
        is_digit  = text_byte >= 8'h30 && text_byte <= 8'h39;
        is_local  = is_letter || is_digit || text_byte == CH_DOT || text_byte == CH_UNDER ||
                    text_byte == CH_PERCENT || text_byte == CH_PLUS || text_byte == CH_MINUS;
    end

    always_comb
    begin
        word_open_next = word_open_reg;
        phase_next     = phase_reg;
        tail_next      = tail_reg;
        word_end.done  = 1'b0;
        word_end.email = phase_reg == PH_TAIL && tail_reg == 2'd2;
        if (step)
        begin
            priority if (end_of_text || text_byte == CH_SPACE)
            begin
                word_end.done  = word_open_reg;
                word_open_next = 1'b0;
                phase_next     = PH_LOCAL_EMPTY;
                tail_next      = 2'd0;
            end
            else if (text_byte == CH_LF || text_byte == CH_CR)
            begin
                word_open_next = 1'b1;
                if (keep_newlines)
                    phase_next = PH_FAIL;
            end
            else
            begin
                word_open_next = 1'b1;
                unique case (phase_reg)
                    PH_LOCAL_EMPTY:
                        phase_next = is_local ? PH_LOCAL : PH_FAIL;
                    PH_LOCAL:
                    begin
                        if (text_byte == CH_AT)
                            phase_next = PH_AT;
                        else if (!is_local)
                            phase_next = PH_FAIL;
                    end
                    PH_AT:
                        phase_next = (is_letter || is_digit || text_byte == CH_MINUS ||
                                      text_byte == CH_DOT) ? PH_DOMAIN : PH_FAIL;
                    PH_DOMAIN, PH_TAIL:
                    begin
                        if (text_byte == CH_DOT)
                        begin
                            phase_next = PH_TAIL;
                            tail_next  = 2'd0;
                        end
                        else if (is_letter)
                        begin
                            if (phase_reg == PH_TAIL && tail_reg != 2'd2)
                                tail_next = tail_reg + 2'd1;
                        end
                        else if (is_digit || text_byte == CH_MINUS)
                        begin
                            phase_next = PH_DOMAIN;
                            tail_next  = 2'd0;
                        end
                        else
                            phase_next = PH_FAIL;
                    end
                    default:
                        phase_next = PH_FAIL;
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_open_reg <= 1'b0;
            phase_reg     <= PH_LOCAL_EMPTY;
            tail_reg      <= 2'd0;
        end
        else
        begin
            word_open_reg <= word_open_next;
            phase_reg     <= phase_next;
            tail_reg      <= tail_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg != PH_LOCAL_EMPTY |-> word_open_reg)
        else $error("scan phase advanced without an open word");
    assert property (@(posedge clk) disable iff (!rst_n)
        tail_reg != 2'd0 |-> phase_reg == PH_TAIL || phase_reg == PH_FAIL)
        else $error("tail letters counted outside the tail");
    assert property (@(posedge clk) disable iff (!rst_n)
        step && end_of_text |=> !word_open_reg && phase_reg == PH_LOCAL_EMPTY)
        else $error("word not cleared at end of text");

endmodule

@@ hw/rtl/email_word_recognizer.sv @@
// Top level of the email word recognizer: stream stages, counter and registers.
//
//  channel | dir | handshake          | payload
//  s_      | in  | s_tvalid/s_tready  | s_tdata text_byte, s_tlast end_of_text
//  m_      | out | m_tvalid/m_tready  | m_tdata email_number, m_tuser is_email/highlight
//  cfg_    | in  | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// One byte per cycle; a result is written to the result register after its closing
// byte has passed the input register. Both stages run while the result register
// is empty or being taken, so a waiting result with m_tready low admits one more
// byte into the input register, then holds s_tready low.
// Reset clears all control state; no clearing pass. Configuration is always ready.
module email_word_recognizer (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [7:0]                          s_tdata,   // [7:0] text_byte
    input  logic                                s_tlast,   // end_of_text
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [15:0]                         m_tdata,   // [15:0] email_number
    output logic [1:0]                          m_tuser,   // [0] is_email, [1] highlight
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [ewr_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [ewr_pkg::CFG_DATA_WIDTH-1:0]  cfg_data
);
    import ewr_pkg::*;

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

    logic [15:0]            first_reg;
    logic [15:0]            last_reg;
    logic                   keep_nl_reg;

    logic                   in_valid_reg;
    logic [7:0]             in_byte_reg;
    logic                   in_last_reg;

    logic                   out_valid_reg;
    logic [15:0]            out_number_reg;
    logic                   out_email_reg;
    logic                   out_hl_reg;

    logic [COUNT_WIDTH-1:0] count_reg, count_next;
    logic [COUNT_WIDTH-1:0] count_inc;
    logic [CMP_WIDTH-1:0]   count_wide;
    logic [15:0]            shown;
    logic                   highlight;
    logic                   out_free;
    logic                   step;
    word_end_t              word_end;

    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || m_tready;
    assign step      = in_valid_reg && out_free;
    assign s_tready  = !in_valid_reg || out_free;

    ewr_scan u_scan (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (step),
        .text_byte     (in_byte_reg),
        .end_of_text   (in_last_reg),
        .keep_newlines (keep_nl_reg),
        .word_end      (word_end)
    );

    always_comb
    begin
        count_inc  = (word_end.email && count_reg != COUNT_MAX) ?
                     count_reg + COUNT_WIDTH'(1) : count_reg;
        count_wide = CMP_WIDTH'(count_inc);
        shown      = (count_wide > CMP_WIDTH'(16'hFFFF)) ? 16'hFFFF : count_wide[15:0];
        highlight  = word_end.email && count_wide >= CMP_WIDTH'(first_reg) &&
                     count_wide <= CMP_WIDTH'(last_reg);
        count_next = count_reg;
        if (step)
        begin
            if (in_last_reg)
                count_next = '0;
            else if (word_end.done)
                count_next = count_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_reg     <= 16'd0;
            last_reg      <= LAST_INDEX_RESET;
            keep_nl_reg   <= 1'b0;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    REG_FIRST_INDEX:   first_reg   <= cfg_data;
                    REG_LAST_INDEX:    last_reg    <= cfg_data;
                    REG_KEEP_NEWLINES: keep_nl_reg <= cfg_data[0];
                    default:           ;
                endcase
            end
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (out_free)
                out_valid_reg <= step && word_end.done;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
        if (step && word_end.done)
        begin
            out_number_reg <= shown;
            out_email_reg  <= word_end.email;
            out_hl_reg     <= highlight;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_number_reg;
    assign m_tuser  = {out_hl_reg, out_email_reg};

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !out_hl_reg || out_email_reg)
        else $error("highlight on a word that is not an email");
    assert property (@(posedge clk) disable iff (!rst_n)
        step && in_last_reg |=> count_reg == '0)
        else $error("counter not cleared at end of text");
    assert property (@(posedge clk) disable iff (!rst_n)
        step && !in_last_reg |=> count_reg >= $past(count_reg))
        else $error("counter went backwards inside a text");
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> s_tready)
        else $error("input stalled with an empty result register");

endmodule
